// ----- design/pbm_pkg.sv -----
// Shared types and constants of the page boundary map.
// Holds field widths, register indexes, request codes, controller states and
// the command/status structs that join the controller to the datapath.
package pbm_pkg;

    // Default table geometry, used as the defaults of the top-level parameters.
    localparam int unsigned DEF_MAX_CHAPTERS = 1024;
    localparam int unsigned DEF_MAX_PAGES    = 8;

    // Field widths of the request and result items.
    localparam int unsigned CHAP_W   = 10;
    localparam int unsigned PAGE_W   = 3;
    localparam int unsigned LIST_W   = 16;
    localparam int unsigned VCHAP_W  = 64;
    localparam int unsigned KIND_W   = 2;

    // Stream payload widths (whole bytes).
    localparam int unsigned S_TDATA_W = 96;
    localparam int unsigned M_TDATA_W = 104;

    // Configuration register widths and port widths.
    localparam int unsigned CFG_CHAP_W  = 11;
    localparam int unsigned CFG_PAGE_W  = 4;
    localparam int unsigned CFG_LIST_W  = 17;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 17;

    // Address arithmetic: base = chapter * (pages - 1), offset is a page number.
    localparam int unsigned BASE_W = CHAP_W + CFG_PAGE_W;
    localparam int unsigned OFF_W  = CFG_PAGE_W;
    localparam int unsigned AT_W   = BASE_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHAPTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LISTS    = 2'd2;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        REQ_UPDATE = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_BOUNDS = 2'd2
    } req_type_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_SCAN0,
        S_SCAN,
        S_BND_LO,
        S_BND_HI,
        S_BND_END,
        S_DONE
    } state_t;

    // Which page offset is added to the chapter base for the table access.
    typedef enum logic [1:0] {
        ADDR_PAGE,
        ADDR_PAGE_PREV,
        ADDR_SCAN,
        ADDR_SCAN_NEXT
    } addr_sel_t;

    typedef struct packed {
        logic      load;      // latch the accepted request
        logic      calc;      // register the chapter base address
        logic      clr;       // clearing pass: zero one table entry
        logic      wr;        // write the update entry
        logic      rd;        // read one table entry
        addr_sel_t addr_sel;
        logic      p_inc;     // advance the scan page
        logic      cap_low;   // capture lowest list from read data
        logic      cap_high;  // capture highest list from read data
        logic      finish;    // load the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              req_ok;
        logic              pg_last;
        logic              scan_empty;
        logic              scan_hit;
        logic              scan_last;
        logic              clr_last;
        logic              out_busy;
    } dp_status_t;

endpackage

// ----- design/page_boundary_map.sv -----
// Top level of the page boundary map: per-chapter table of index page bounds.
// Instantiates pbm_ctrl and pbm_datapath; types and constants come from pbm_pkg.
//
// Requests enter on the s_ stream channel with the request kind in s_tuser
// (0 update, 1 find, 2 bounds); each gives one result on the m_ channel, with
// the status flag in m_tuser and the found page, list bounds and last updated
// virtual chapter in m_tdata. The cfg_ channel writes chapters in use, pages
// per chapter and lists per chapter; it is always ready. The user must write it
// only while no request is in flight; the block itself does not enforce this.
// One request is worked on at a time: an update that writes the table passes
// the check and write states, a bounds query the check, the low and high reads
// and the high capture, a find the check and a scan of k (1 to pages-1)
// entries, one per cycle from the single-port table memory; refused requests,
// updates of the last page and finds over a single page go from the check
// straight to done. aresetn is synchronous and active low. After reset the
// block zeroes all MAX_CHAPTERS * (MAX_PAGES - 1) table entries (7168 by
// default), one entry per cycle, with s_tready low; cfg_ writes are still taken.
// A result waits in an output register for m_tready; meanwhile the next
// request is accepted and worked on, and its result is held until the
// register is free, so s_tready then stays low.
module page_boundary_map #(
    parameter int unsigned MAX_CHAPTERS = pbm_pkg::DEF_MAX_CHAPTERS,
    parameter int unsigned MAX_PAGES    = pbm_pkg::DEF_MAX_PAGES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, lowest bit first: virtual_chapter[63:0], chapter[73:64],
    // page[76:74], list_number[92:77], zero fill[95:93].
    input  logic [pbm_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: req_type[1:0].
    input  logic [pbm_pkg::KIND_W-1:0]          s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, lowest bit first: found_page[2:0], low_bound[18:3],
    // high_bound[34:19], newest_vchap[98:35], zero fill[103:99].
    output logic [pbm_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser: status[0] (1 means invalid argument).
    output logic [0:0]                          m_tuser,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pbm_pkg::dp_cmd_t    cmd;
    pbm_pkg::dp_status_t st;

    // The controller decides which table access happens in each cycle.
    pbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the table, the range checks and the output register.
    pbm_datapath #(
        .MAX_CHAPTERS (MAX_CHAPTERS),
        .MAX_PAGES    (MAX_PAGES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- design/pbm_datapath.sv -----
// Datapath of the page boundary map: configuration registers, request
// registers, the boundary table memory, range checks and the output register.
// Depends on pbm_pkg; sequenced by pbm_ctrl.
module pbm_datapath #(
    parameter int unsigned MAX_CHAPTERS = pbm_pkg::DEF_MAX_CHAPTERS,
    parameter int unsigned MAX_PAGES    = pbm_pkg::DEF_MAX_PAGES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pbm_pkg::dp_cmd_t                    cmd,
    output pbm_pkg::dp_status_t                 st,
    input  logic [pbm_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [pbm_pkg::KIND_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pbm_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned TABLE_DEPTH = MAX_CHAPTERS * (MAX_PAGES - 1);
    localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Configuration registers.
    logic [pbm_pkg::CFG_CHAP_W-1:0] cfg_chapters_reg;
    logic [pbm_pkg::CFG_PAGE_W-1:0] cfg_pages_reg;
    logic [pbm_pkg::CFG_LIST_W-1:0] cfg_lists_reg;

    // Request registers.
    logic [pbm_pkg::KIND_W-1:0]  kind_reg;
    logic [pbm_pkg::CHAP_W-1:0]  chap_reg;
    logic [pbm_pkg::PAGE_W-1:0]  page_reg;
    logic [pbm_pkg::LIST_W-1:0]  list_reg;
    logic [pbm_pkg::VCHAP_W-1:0] newest_vchap_reg;

    logic [pbm_pkg::BASE_W-1:0]  base_reg;
    logic [pbm_pkg::BASE_W-1:0]  base_next;
    logic [pbm_pkg::OFF_W-1:0]   p_reg;
    logic [pbm_pkg::OFF_W-1:0]   p_next;
    logic [ADDR_W-1:0]           clr_reg;

    logic [pbm_pkg::LIST_W-1:0]  rd_data_reg;
    logic                        rd_ok_reg;
    logic [pbm_pkg::LIST_W-1:0]  low_reg;
    logic [pbm_pkg::LIST_W-1:0]  high_reg;

    logic                        m_valid_reg;
    logic [pbm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                        m_tuser_reg;

    logic [pbm_pkg::LIST_W-1:0]  mem [TABLE_DEPTH];

    // Effective configuration and range checks.
    logic [pbm_pkg::CFG_PAGE_W-1:0] npg_eff;
    logic [pbm_pkg::CFG_PAGE_W-1:0] npg_m1;
    logic [pbm_pkg::CFG_LIST_W-1:0] nls_eff;
    logic [pbm_pkg::CFG_LIST_W-1:0] nls_m1;
    logic                           chap_ok;
    logic                           pg_ok;
    logic                           list_ok;
    logic                           pg_last;
    logic                           req_ok;

    logic [pbm_pkg::OFF_W-1:0]   off;
    logic [pbm_pkg::AT_W-1:0]    at;
    logic                        at_ok;
    logic [ADDR_W-1:0]           mem_addr;
    logic                        mem_we;
    logic [pbm_pkg::LIST_W-1:0]  mem_wdata;
    logic [pbm_pkg::LIST_W-1:0]  entry;
    logic [pbm_pkg::LIST_W-1:0]  low_val;
    logic [pbm_pkg::LIST_W-1:0]  high_val;

    assign npg_eff = (32'(cfg_pages_reg) > MAX_PAGES) ? pbm_pkg::CFG_PAGE_W'(MAX_PAGES)
                                                      : cfg_pages_reg;
    assign npg_m1  = npg_eff - 4'd1;
    assign nls_eff = (cfg_lists_reg > 17'h10000) ? 17'h10000 : cfg_lists_reg;
    assign nls_m1  = nls_eff - 17'd1;

    assign chap_ok = (32'(chap_reg) < 32'(cfg_chapters_reg)) && (32'(chap_reg) < MAX_CHAPTERS);
    assign pg_ok   = {1'b0, page_reg} < npg_eff;
    assign list_ok = {1'b0, list_reg} < cfg_lists_reg;
    assign pg_last = {1'b0, page_reg} == npg_m1;

    always_comb begin
        case (kind_reg)
            pbm_pkg::REQ_UPDATE: req_ok = chap_ok && pg_ok && list_ok;
            pbm_pkg::REQ_FIND:   req_ok = chap_ok && (npg_eff != 4'd0);
            pbm_pkg::REQ_BOUNDS: req_ok = chap_ok && pg_ok;
            default:             req_ok = 1'b0;
        endcase
    end

    // Table address: chapter base plus a page offset.
    assign base_next = {4'b0, chap_reg} * {10'b0, npg_m1};
    assign p_next    = p_reg + 4'd1;

    always_comb begin
        case (cmd.addr_sel)
            pbm_pkg::ADDR_PAGE:      off = {1'b0, page_reg};
            pbm_pkg::ADDR_PAGE_PREV: off = {1'b0, page_reg} - 4'd1;
            pbm_pkg::ADDR_SCAN:      off = p_reg;
            pbm_pkg::ADDR_SCAN_NEXT: off = p_next;
            default:                 off = p_reg;
        endcase
    end

    assign at        = {1'b0, base_reg} + {11'b0, off};
    assign at_ok     = 32'(at) < TABLE_DEPTH;
    assign mem_addr  = cmd.clr ? clr_reg : ADDR_W'(at);
    assign mem_we    = cmd.clr || (cmd.wr && at_ok);
    assign mem_wdata = cmd.clr ? '0 : list_reg;

    // Entries beyond the table read as zero.
    assign entry    = rd_ok_reg ? rd_data_reg : '0;
    assign low_val  = (page_reg == 3'd0)     ? '0 :
                      (entry == 16'hFFFF)    ? 16'hFFFF : entry + 16'd1;
    assign high_val = pg_last ? nls_m1[pbm_pkg::LIST_W-1:0] : entry;

    // Single-port table memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (cmd.rd) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_ok_reg <= at_ok;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_chapters_reg <= 11'd1024;
            cfg_pages_reg    <= 4'd8;
            cfg_lists_reg    <= 17'h10000;
        end else if (cfg_valid) begin
            case (cfg_index)
                pbm_pkg::REG_CHAPTERS: cfg_chapters_reg <= cfg_data[pbm_pkg::CFG_CHAP_W-1:0];
                pbm_pkg::REG_PAGES:    cfg_pages_reg    <= cfg_data[pbm_pkg::CFG_PAGE_W-1:0];
                pbm_pkg::REG_LISTS:    cfg_lists_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control-side registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_vchap_reg <= '0;
            p_reg            <= '0;
            clr_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.load && (s_tuser == pbm_pkg::REQ_UPDATE)) begin
                newest_vchap_reg <= s_tdata[63:0];
            end
            if (cmd.load) begin
                p_reg <= '0;
            end else if (cmd.p_inc) begin
                p_reg <= p_next;
            end
            if (cmd.clr) begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_tuser;
            chap_reg <= s_tdata[73:64];
            page_reg <= s_tdata[76:74];
            list_reg <= s_tdata[92:77];
            low_reg  <= '0;
            high_reg <= '0;
        end else begin
            if (cmd.cap_low) begin
                low_reg <= low_val;
            end
            if (cmd.cap_high) begin
                high_reg <= high_val;
            end
        end
        if (cmd.calc) begin
            base_reg <= base_next;
        end
        if (cmd.finish) begin
            m_tdata_reg <= {5'b0, newest_vchap_reg, high_reg, low_reg, p_reg[2:0]};
            m_tuser_reg <= !req_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign st.kind       = kind_reg;
    assign st.req_ok     = req_ok;
    assign st.pg_last    = pg_last;
    assign st.scan_empty = npg_m1 == 4'd0;
    assign st.scan_hit   = rd_ok_reg && (list_reg <= rd_data_reg);
    assign st.scan_last  = p_next == npg_m1;
    assign st.clr_last   = clr_reg == ADDR_W'(TABLE_DEPTH - 1);
    assign st.out_busy   = m_valid_reg && !m_tready;

endmodule

// ----- design/pbm_ctrl.sv -----
// Controller of the page boundary map: sequences the clearing pass and the
// table accesses of each request. Depends on pbm_pkg; drives pbm_datapath.
module pbm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pbm_pkg::dp_status_t st,
    output pbm_pkg::dp_cmd_t    cmd
);

    pbm_pkg::state_t state_reg;
    pbm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbm_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pbm_pkg::S_CLEAR: begin
                if (st.clr_last) state_next = pbm_pkg::S_IDLE;
            end
            pbm_pkg::S_IDLE: begin
                if (s_tvalid) state_next = pbm_pkg::S_CHECK;
            end
            pbm_pkg::S_CHECK: begin
                case (st.kind)
                    pbm_pkg::REQ_UPDATE: begin
                        state_next = (st.req_ok && !st.pg_last) ? pbm_pkg::S_WRITE
                                                                : pbm_pkg::S_DONE;
                    end
                    pbm_pkg::REQ_FIND: begin
                        state_next = (st.req_ok && !st.scan_empty) ? pbm_pkg::S_SCAN0
                                                                   : pbm_pkg::S_DONE;
                    end
                    pbm_pkg::REQ_BOUNDS: begin
                        state_next = st.req_ok ? pbm_pkg::S_BND_LO : pbm_pkg::S_DONE;
                    end
                    default: state_next = pbm_pkg::S_DONE;
                endcase
            end
            pbm_pkg::S_WRITE:   state_next = pbm_pkg::S_DONE;
            pbm_pkg::S_SCAN0:   state_next = pbm_pkg::S_SCAN;
            pbm_pkg::S_SCAN: begin
                if (st.scan_hit || st.scan_last) state_next = pbm_pkg::S_DONE;
            end
            pbm_pkg::S_BND_LO:  state_next = pbm_pkg::S_BND_HI;
            pbm_pkg::S_BND_HI:  state_next = pbm_pkg::S_BND_END;
            pbm_pkg::S_BND_END: state_next = pbm_pkg::S_DONE;
            pbm_pkg::S_DONE: begin
                if (!st.out_busy) state_next = pbm_pkg::S_IDLE;
            end
            default: state_next = pbm_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.addr_sel = pbm_pkg::ADDR_PAGE;
        s_tready     = 1'b0;
        case (state_reg)
            pbm_pkg::S_CLEAR: cmd.clr = 1'b1;
            pbm_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            pbm_pkg::S_CHECK: cmd.calc = 1'b1;
            pbm_pkg::S_WRITE: cmd.wr = 1'b1;
            pbm_pkg::S_SCAN0: begin
                cmd.rd       = 1'b1;
                cmd.addr_sel = pbm_pkg::ADDR_SCAN;
            end
            pbm_pkg::S_SCAN: begin
                // Check the entry of the current page while fetching the next one.
                if (!st.scan_hit) begin
                    cmd.p_inc = 1'b1;
                    if (!st.scan_last) begin
                        cmd.rd       = 1'b1;
                        cmd.addr_sel = pbm_pkg::ADDR_SCAN_NEXT;
                    end
                end
            end
            pbm_pkg::S_BND_LO: begin
                cmd.rd       = 1'b1;
                cmd.addr_sel = pbm_pkg::ADDR_PAGE_PREV;
            end
            pbm_pkg::S_BND_HI: begin
                cmd.rd       = 1'b1;
                cmd.addr_sel = pbm_pkg::ADDR_PAGE;
                cmd.cap_low  = 1'b1;
            end
            pbm_pkg::S_BND_END: cmd.cap_high = 1'b1;
            pbm_pkg::S_DONE:    cmd.finish = !st.out_busy;
            default: ;
        endcase
    end

    // The output register is only loaded once the previous result has left.
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !st.out_busy)
        else $error("result loaded over a pending result");

    // At most one table access per cycle on the single port.
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr, cmd.wr, cmd.rd}))
        else $error("more than one table access in a cycle");

    // No request is taken before the clearing pass has finished.
    a_no_load_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pbm_pkg::S_CLEAR) |=> !cmd.load || $past(st.clr_last))
        else $error("request accepted during clearing pass");

    // A scan only runs for find requests.
    a_scan_is_find: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pbm_pkg::S_SCAN) |-> (st.kind == pbm_pkg::REQ_FIND))
        else $error("table scan outside a find request");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for page_boundary_map: directed and random requests with
// random stalls on both stream sides, checked against a built-in table predictor.
// Depends on pbm_pkg for widths, request codes and register indexes.
module tb_top;

    localparam int unsigned TABLE_DEPTH =
        pbm_pkg::DEF_MAX_CHAPTERS * (pbm_pkg::DEF_MAX_PAGES - 1);
    localparam int unsigned LIST_SPAN        = 1 << pbm_pkg::LIST_W;
    localparam logic [pbm_pkg::KIND_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int          WATCHDOG_LIMIT   = 30000;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES      = 32;
    localparam int          PHASES           = 12;
    localparam int          ITEMS_PER_PHASE  = 94;

    // Mirror of the boundary table. Every accepted request is turned into the
    // answer the block must give, and answers are checked in arrival order.
    class page_map_scoreboard;
        typedef struct {
            logic                       status;
            logic [pbm_pkg::PAGE_W-1:0] found_page;
            logic [pbm_pkg::LIST_W-1:0] low_bound;
            logic [pbm_pkg::LIST_W-1:0] high_bound;
            logic [63:0]                newest_vchap;
        } answer_t;

        logic [pbm_pkg::LIST_W-1:0] boundary_copy [TABLE_DEPTH];
        logic [63:0]       last_vchap;
        int unsigned       chapters_reg;
        int unsigned       pages_reg;
        int unsigned       lists_reg;
        answer_t           expected_answers [$];
        int                answers_seen;
        int                mismatches;

        function new();
            foreach (boundary_copy[i]) boundary_copy[i] = '0;
            last_vchap   = '0;
            chapters_reg = pbm_pkg::DEF_MAX_CHAPTERS;
            pages_reg    = pbm_pkg::DEF_MAX_PAGES;
            lists_reg    = LIST_SPAN;
            answers_seen = 0;
            mismatches   = 0;
        endfunction

        // Register values above the table size act as the table size.
        function int unsigned eff_chapters();
            return (chapters_reg > pbm_pkg::DEF_MAX_CHAPTERS) ? pbm_pkg::DEF_MAX_CHAPTERS
                                                              : chapters_reg;
        endfunction

        function int unsigned eff_pages();
            return (pages_reg > pbm_pkg::DEF_MAX_PAGES) ? pbm_pkg::DEF_MAX_PAGES : pages_reg;
        endfunction

        function int unsigned eff_lists();
            return (lists_reg > LIST_SPAN) ? LIST_SPAN : lists_reg;
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        function void note_config(logic [pbm_pkg::CFG_IDX_W-1:0] idx,
                                  logic [pbm_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                pbm_pkg::REG_CHAPTERS: chapters_reg = val[pbm_pkg::CFG_CHAP_W-1:0];
                pbm_pkg::REG_PAGES:    pages_reg    = val[pbm_pkg::CFG_PAGE_W-1:0];
                pbm_pkg::REG_LISTS:    lists_reg    = val[pbm_pkg::CFG_LIST_W-1:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted request to the mirror and queues its answer.
        function void note_request(logic [pbm_pkg::KIND_W-1:0] kind, logic [63:0] vchap,
                                   logic [pbm_pkg::CHAP_W-1:0] chap,
                                   logic [pbm_pkg::PAGE_W-1:0] pg,
                                   logic [pbm_pkg::LIST_W-1:0] lst);
            int unsigned nch, npg, nls, base, at, p, e;
            answer_t ans;
            nch = eff_chapters();
            npg = eff_pages();
            nls = eff_lists();
            ans.status     = 1'b1;
            ans.found_page = '0;
            ans.low_bound  = '0;
            ans.high_bound = '0;
            case (kind)
                pbm_pkg::REQ_UPDATE: begin
                    // The virtual chapter is recorded even when the checks fail.
                    last_vchap = vchap;
                    if (chap < nch && pg < npg && lst < nls) begin
                        ans.status = 1'b0;
                        if (pg != npg - 1) begin
                            at = chap * (npg - 1) + pg;
                            if (at < TABLE_DEPTH) boundary_copy[at] = lst;
                        end
                    end
                end
                pbm_pkg::REQ_FIND: begin
                    // Only the chapter is range-checked here.
                    if (chap < nch && npg > 0) begin
                        base = chap * (npg - 1);
                        p = 0;
                        while (p < npg - 1) begin
                            at = base + p;
                            if (at < TABLE_DEPTH && lst <= boundary_copy[at]) break;
                            p++;
                        end
                        ans.found_page = p[pbm_pkg::PAGE_W-1:0];
                        ans.status     = 1'b0;
                    end
                end
                pbm_pkg::REQ_BOUNDS: begin
                    if (chap < nch && pg < npg) begin
                        base = chap * (npg - 1);
                        if (pg != 0) begin
                            at = base + pg - 1;
                            e = (at < TABLE_DEPTH) ? 32'(boundary_copy[at]) : 0;
                            // A full previous entry saturates instead of wrapping.
                            ans.low_bound = pbm_pkg::LIST_W'((e >= 32'hFFFF) ? 32'hFFFF
                                                                             : e + 1);
                        end
                        if (pg == npg - 1) begin
                            ans.high_bound = pbm_pkg::LIST_W'(nls - 1);
                        end else begin
                            at = base + pg;
                            ans.high_bound = (at < TABLE_DEPTH) ? boundary_copy[at] : '0;
                        end
                        ans.status = 1'b0;
                    end
                end
                default: ;
            endcase
            ans.newest_vchap = last_vchap;
            expected_answers.push_back(ans);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("ERROR: %s", msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("answer %0d: %s is 0x%0h, expected 0x%0h",
                                          answers_seen, name, got, want));
        endtask

        task check_answer(logic status, logic [pbm_pkg::M_TDATA_W-1:0] tdata);
            answer_t want;
            answers_seen++;
            if (expected_answers.size() == 0) begin
                report_mismatch($sformatf("answer %0d arrived with no request waiting",
                                          answers_seen));
                return;
            end
            want = expected_answers.pop_front();
            compare_field("status", 64'(status), 64'(want.status));
            compare_field("found page", 64'(tdata[2:0]), 64'(want.found_page));
            compare_field("low bound", 64'(tdata[18:3]), 64'(want.low_bound));
            compare_field("high bound", 64'(tdata[34:19]), 64'(want.high_bound));
            compare_field("newest virtual chapter", tdata[98:35], want.newest_vchap);
        endtask
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [pbm_pkg::S_TDATA_W-1:0]      s_tdata;
    logic [pbm_pkg::KIND_W-1:0]         s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [pbm_pkg::M_TDATA_W-1:0]      m_tdata;
    logic [0:0]                         m_tuser;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [pbm_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [pbm_pkg::CFG_DATA_W-1:0]     cfg_data;

    page_map_scoreboard sb = new();

    // Quiet stretches: while a counter is nonzero that side never idles.
    int send_quiet = 0;
    int recv_quiet = 0;
    // Set by the stimulus to make the result side hold off for a long time.
    bit long_hold_req = 1'b0;
    int idle_cycles = 0;

    page_boundary_map dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Picks how many cycles a side waits before its next request. Most draws
    // are uniform, but now and then a run of draws with no wait starts.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Offers one request and returns in the time step it is accepted. The
    // caller must issue the next request, or lower s_tvalid, without advancing
    // time, so that a request is never taken twice.
    task automatic send_request(input logic [pbm_pkg::KIND_W-1:0] kind,
                                input logic [63:0] vchap,
                                input logic [pbm_pkg::CHAP_W-1:0] chap,
                                input logic [pbm_pkg::PAGE_W-1:0] pg,
                                input logic [pbm_pkg::LIST_W-1:0] lst);
        int wait_cycles;
        wait_cycles = draw_wait(send_quiet);
        if (wait_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (wait_cycles) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, lst, pg, chap, vchap};
        // Handshake signals read right after the edge still hold the values
        // that the edge sampled.
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, vchap, chap, pg, lst);
    endtask

    // Lowers the request valid and waits until every answer has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() > 0);
    endtask

    // Writes one register and leaves cfg_valid high for a following write.
    task automatic write_reg(input logic [pbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbm_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(idx, val);
    endtask

    task automatic set_geometry(input logic [pbm_pkg::CFG_DATA_W-1:0] chapters,
                                input logic [pbm_pkg::CFG_DATA_W-1:0] pages,
                                input logic [pbm_pkg::CFG_DATA_W-1:0] lists);
        write_reg(pbm_pkg::REG_CHAPTERS, chapters);
        write_reg(pbm_pkg::REG_PAGES, pages);
        write_reg(pbm_pkg::REG_LISTS, lists);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed requests aimed at a few hot chapters so that finds
    // and bounds see entries written earlier; the rest is unconstrained noise.
    task automatic send_random_request();
        int unsigned nch, npg, nls, roll, hot, near;
        logic [pbm_pkg::KIND_W-1:0] kind;
        logic [pbm_pkg::CHAP_W-1:0] chap;
        logic [pbm_pkg::PAGE_W-1:0] pg;
        logic [pbm_pkg::LIST_W-1:0] lst;
        nch = sb.eff_chapters();
        npg = sb.eff_pages();
        nls = sb.eff_lists();
        roll = $urandom_range(0, 99);
        if (roll < 40) kind = pbm_pkg::REQ_UPDATE;
        else if (roll < 70) kind = pbm_pkg::REQ_FIND;
        else if (roll < 97) kind = pbm_pkg::REQ_BOUNDS;
        else kind = REQ_UNKNOWN;
        if ($urandom_range(0, 9) < 8 && nch > 0 && npg > 0 && nls > 0) begin
            hot = $urandom_range(0, (nch > 4) ? 3 : nch - 1);
            case ($urandom_range(0, 3))
                0, 1:    chap = pbm_pkg::CHAP_W'(hot);
                2:       chap = pbm_pkg::CHAP_W'(nch - 1 - hot);
                default: chap = pbm_pkg::CHAP_W'($urandom_range(0, nch - 1));
            endcase
            pg = pbm_pkg::PAGE_W'($urandom_range(0, npg - 1));
            near = $urandom_range(0, (nls > 16) ? 15 : nls - 1);
            case ($urandom_range(0, 2))
                0:       lst = pbm_pkg::LIST_W'(near);
                1:       lst = pbm_pkg::LIST_W'(nls - 1 - near);
                default: lst = pbm_pkg::LIST_W'($urandom_range(0, nls - 1));
            endcase
        end else begin
            chap = pbm_pkg::CHAP_W'($urandom_range(0, 1023));
            pg   = pbm_pkg::PAGE_W'($urandom_range(0, 7));
            lst  = pbm_pkg::LIST_W'($urandom_range(0, 65535));
        end
        send_request(kind, {$urandom, $urandom}, chap, pg, lst);
    endtask

    // Result side: waits a random number of cycles before each answer, and
    // once in a while holds off for a long stretch so the block backs up.
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end
            stall = draw_wait(recv_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_answer(m_tuser[0], m_tdata);
        end
    end

    // The watchdog counts cycles in which no channel moves anything. The
    // clearing pass after reset and the long hold-off both stay well below it.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= pbm_pkg::REQ_UPDATE;
        cfg_valid <= 1'b0;
        cfg_index <= pbm_pkg::REG_CHAPTERS;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn   <= 1'b1;

        // Directed part under the reset geometry. The table starts cleared, so
        // bounds of the last page read one above a zero entry.
        send_request(pbm_pkg::REQ_BOUNDS, '0, 10'd0, 3'd0, 16'd0);
        send_request(pbm_pkg::REQ_BOUNDS, '0, 10'd1023, 3'd7, 16'd0);
        send_request(pbm_pkg::REQ_FIND, '0, 10'd0, 3'd0, 16'd0);
        // A find with no qualifying entry answers the last page.
        send_request(pbm_pkg::REQ_FIND, '0, 10'd5, 3'd0, 16'd1);
        send_request(pbm_pkg::REQ_UPDATE, '1, 10'd1023, 3'd0, 16'hFFFF);
        send_request(pbm_pkg::REQ_UPDATE, 64'h0123_4567_89AB_CDEF, 10'd1023, 3'd1, 16'hFFFF);
        // A full entry before the page makes the lowest list saturate.
        send_request(pbm_pkg::REQ_BOUNDS, '0, 10'd1023, 3'd2, 16'd0);
        send_request(pbm_pkg::REQ_FIND, '0, 10'd1023, 3'd0, 16'hFFFF);
        // Updates of the last page succeed but store nothing.
        send_request(pbm_pkg::REQ_UPDATE, '0, 10'd1023, 3'd7, 16'd1234);
        send_request(pbm_pkg::REQ_BOUNDS, '0, 10'd1023, 3'd7, 16'd0);
        for (int p = 0; p < 7; p++)
            send_request(pbm_pkg::REQ_UPDATE, 64'(p + 1), 10'd5, 3'(p), 16'(100 * (p + 1)));
        send_request(pbm_pkg::REQ_FIND, '0, 10'd5, 3'd0, 16'd350);
        send_request(pbm_pkg::REQ_FIND, '0, 10'd5, 3'd0, 16'd701);
        send_request(pbm_pkg::REQ_BOUNDS, '0, 10'd5, 3'd3, 16'd0);
        // An unknown request kind is refused and changes nothing.
        send_request(REQ_UNKNOWN, '1, 10'h3FF, 3'd7, 16'hFFFF);
        send_request(pbm_pkg::REQ_UPDATE, {$urandom, $urandom}, 10'd2, 3'd6, 16'd4242);
        wait_drained();

        // Random phases, each under its own geometry. The first few cover the
        // extremes: values above the table size, all zero, the smallest
        // usable geometry, the reset values and zero lists per chapter.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_geometry(17'd2047, 17'd15, 17'd131071);
                1: set_geometry(17'd0, 17'd0, 17'd0);
                2: set_geometry(17'd1, 17'd1, 17'd1);
                3: set_geometry(17'd1024, 17'd8, 17'd65536);
                4: set_geometry(17'd3, 17'd2, 17'd0);
                5: set_geometry(17'd1000, 17'd8, 17'd65535);
                default: set_geometry(
                    pbm_pkg::CFG_DATA_W'(($urandom_range(0, 7) == 0)
                                         ? $urandom_range(0, 2047)
                                         : $urandom_range(1, 1024)),
                    pbm_pkg::CFG_DATA_W'(($urandom_range(0, 7) == 0)
                                         ? $urandom_range(0, 15)
                                         : $urandom_range(1, 8)),
                    pbm_pkg::CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                         ? $urandom_range(1, 64)
                                         : ($urandom_range(0, 7) == 0)
                                           ? $urandom_range(0, 131071)
                                           : $urandom_range(1, 65536)));
            endcase
            // Back pressure: the result side stalls while requests keep coming.
            if (phase == 0 || phase == 7) long_hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_request();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
